[design/ibfr_pkg.sv]
// ============================================================================
// ibfr_pkg: shared types and constants for the serial frame receiver
// Frame layout, field widths and the command/status bundles between the
// controller and the datapath.
// ============================================================================
`default_nettype none

package ibfr_pkg;

    localparam int CHANNELS   = 14;
    localparam int POS_W      = 5;
    localparam int IDX_W      = 4;
    localparam int VAL_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [BYTE_W-1:0] HDR0     = 8'h20;
    localparam logic [BYTE_W-1:0] HDR1     = 8'h40;
    localparam logic [VAL_W-1:0]  SUM_INIT = 16'hFFFF;

    localparam logic [POS_W-1:0] POS_HUNT   = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1   = 5'd1;
    localparam logic [POS_W-1:0] DATA_START = 5'd2;
    localparam logic [POS_W-1:0] CSUM_LO    = POS_W'(2 + 2 * CHANNELS);
    localparam logic [POS_W-1:0] CSUM_HI    = POS_W'(3 + 2 * CHANNELS);
    localparam logic [IDX_W-1:0] LAST_CH    = IDX_W'(CHANNELS - 1);

    typedef struct packed {
        logic rx_en;
        logic rd_clr;
        logic rd_inc;
        logic ld_chan;
        logic ld_err;
    } ibfr_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic csum_ok;
        logic out_last;
    } ibfr_sts_t;

endpackage

`default_nettype wire

[design/ibus_frame_receiver.sv]
// After the checksum high byte the first result shows in the next cycle on a
// mismatch, and after the store read and load states on a match.
// Throughput: one byte per cycle within a frame; each of a good frame's 14
// results takes a store read, a load and a present step, the last held while
// m_tready is low, with input held off meanwhile. Reset clears position,
// checksum and control; the channel store is not cleared.
// ============================================================================
// ibus_frame_receiver: serial byte stream frame decoder
// Hunts for the frame header, collects little-endian channel words, checks
// the frame checksum and emits every channel or one error result.
// ============================================================================
`default_nettype none

module ibus_frame_receiver import ibfr_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // [3:0] channel_index, [19:4] channel_value
    output logic                      m_tuser,   // [0] status
    output logic                      m_tlast
);

    ibfr_cmd_t        cmd;
    ibfr_sts_t        sts;
    logic             out_err;
    logic [IDX_W-1:0] out_idx;
    logic [VAL_W-1:0] out_val;
    logic             out_last;

    ibfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ibfr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rx_byte  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .out_err  (out_err),
        .out_idx  (out_idx),
        .out_val  (out_val),
        .out_last (out_last)
    );

    assign m_tdata = {(M_TDATA_W - IDX_W - VAL_W)'(0), out_val, out_idx};
    assign m_tuser = out_err;
    assign m_tlast = out_last;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("error result not a cleared last transaction");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast == (m_tdata[IDX_W-1:0] == LAST_CH)))
        else $error("last mark does not match final channel");

    a_resume: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("input not resumed after frame readout");
`endif

endmodule

`default_nettype wire

[design/ibfr_ram.sv]
// ============================================================================
// ibfr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module ibfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/ibfr_dp.sv]
// ============================================================================
// ibfr_dp: receiver datapath
// Frame position, running checksum, low byte hold, channel store, readout
// index and the result register.
// ============================================================================
`default_nettype none

module ibfr_dp import ibfr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [BYTE_W-1:0]     rx_byte,
    input  wire ibfr_cmd_t             cmd,
    output ibfr_sts_t                  sts,
    output logic                       out_err,
    output logic      [IDX_W-1:0]      out_idx,
    output logic      [VAL_W-1:0]      out_val,
    output logic                       out_last
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [VAL_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0] hold_reg, hold_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              out_err_reg, out_err_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [VAL_W-1:0]  out_val_reg, out_val_next;
    logic              out_last_reg, out_last_next;

    logic [POS_W-1:0]  off;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [VAL_W-1:0]  wdata;
    logic [VAL_W-1:0]  rdata;

    assign off   = pos_reg - DATA_START;
    assign waddr = off[POS_W-1:1];
    assign wdata = {rx_byte, hold_reg};

    always_comb begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        hold_next = hold_reg;
        we        = 1'b0;
        if (cmd.rx_en) begin
            if (pos_reg == POS_HUNT) begin
                if (rx_byte == HDR0) begin
                    sum_next = SUM_INIT - {8'h00, HDR0};
                    pos_next = POS_HDR1;
                end
            end else if (pos_reg == POS_HDR1) begin
                if (rx_byte == HDR1) begin
                    sum_next = sum_reg - {8'h00, HDR1};
                    pos_next = DATA_START;
                end else begin
                    pos_next = POS_HUNT;
                end
            end else if (pos_reg < CSUM_LO) begin
                sum_next = sum_reg - {8'h00, rx_byte};
                if (!off[0]) begin
                    hold_next = rx_byte;
                end else begin
                    we = 1'b1;
                end
                pos_next = pos_reg + POS_W'(1);
            end else if (pos_reg == CSUM_LO) begin
                hold_next = rx_byte;
                pos_next  = pos_reg + POS_W'(1);
            end else begin
                pos_next = POS_HUNT;
            end
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_clr) begin
            rd_idx_next = '0;
        end else if (cmd.rd_inc) begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        out_err_next  = out_err_reg;
        out_idx_next  = out_idx_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        if (cmd.ld_err) begin
            out_err_next  = 1'b1;
            out_idx_next  = '0;
            out_val_next  = '0;
            out_last_next = 1'b1;
        end else if (cmd.ld_chan) begin
            out_err_next  = 1'b0;
            out_idx_next  = rd_idx_reg;
            out_val_next  = rdata;
            out_last_next = (rd_idx_reg == LAST_CH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_HUNT;
            sum_reg      <= SUM_INIT;
            hold_reg     <= '0;
            rd_idx_reg   <= '0;
            out_last_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            hold_reg     <= hold_next;
            rd_idx_reg   <= rd_idx_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_err_reg <= out_err_next;
        out_idx_reg <= out_idx_next;
        out_val_reg <= out_val_next;
    end

    ibfr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CHANNELS)
    ) u_store (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    assign sts.frame_end = (pos_reg == CSUM_HI);
    assign sts.csum_ok   = ({rx_byte, hold_reg} == sum_reg);
    assign sts.out_last  = out_last_reg;

    assign out_err  = out_err_reg;
    assign out_idx  = out_idx_reg;
    assign out_val  = out_val_reg;
    assign out_last = out_last_reg;

endmodule

`default_nettype wire

[design/ibfr_ctrl.sv]
// ============================================================================
// ibfr_ctrl: receiver controller
// Takes bytes, and at frame end either loads an error result or sequences
// the channel readout one store read per result.
// ============================================================================
`default_nettype none

module ibfr_ctrl import ibfr_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire ibfr_sts_t sts,
    output ibfr_cmd_t      cmd
);

    localparam logic [1:0] ST_RX  = 2'd0;
    localparam logic [1:0] ST_RD  = 2'd1;
    localparam logic [1:0] ST_LD  = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_RX: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.rx_en = 1'b1;
                    if (sts.frame_end) begin
                        if (sts.csum_ok) begin
                            cmd.rd_clr = 1'b1;
                            state_next = ST_RD;
                        end else begin
                            cmd.ld_err = 1'b1;
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_RD: begin
                state_next = ST_LD;
            end
            ST_LD: begin
                cmd.ld_chan = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (sts.out_last) begin
                        state_next = ST_RX;
                    end else begin
                        cmd.rd_inc = 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_RX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RX;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[bench/ibfr_checker.sv]
// ============================================================================
// ibfr_checker: result predictor and scoreboard for the frame receiver
// Watches both stream channels. Every byte transaction goes through a
// behavioral copy of the frame decoder; the results that it predicts are
// queued and compared, field by field, with each result transaction.
// ============================================================================
module ibfr_checker import ibfr_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tuser,
    input  wire logic                 m_tlast,
    output int                        fail_count,
    output int                        pending
);

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_CSUM_ERR = 1'b1;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] chan_idx;
        logic [VAL_W-1:0] chan_val;
        logic             is_last;
    } chan_result_t;

    logic [POS_W-1:0]  byte_pos;
    logic [VAL_W-1:0]  frame_sum;
    logic [BYTE_W-1:0] low_hold;
    logic [VAL_W-1:0]  chan_words [CHANNELS];
    chan_result_t      results_due [$];
    int                n_fail;

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [POS_W-1:0] off;
        chan_result_t     r;
        if (byte_pos == POS_HUNT) begin
            if (b == HDR0) begin
                frame_sum = SUM_INIT - VAL_W'(HDR0);
                byte_pos  = POS_HDR1;
            end
        end else if (byte_pos == POS_HDR1) begin
            if (b == HDR1) begin
                frame_sum = frame_sum - VAL_W'(HDR1);
                byte_pos  = DATA_START;
            end else begin
                byte_pos = POS_HUNT;
            end
        end else if (byte_pos < CSUM_LO) begin
            off       = byte_pos - DATA_START;
            frame_sum = frame_sum - VAL_W'(b);
            if (!off[0])
                low_hold = b;
            else
                chan_words[off[POS_W-1:1]] = {b, low_hold};
            byte_pos = byte_pos + POS_W'(1);
        end else if (byte_pos == CSUM_LO) begin
            low_hold = b;
            byte_pos = byte_pos + POS_W'(1);
        end else if (byte_pos == CSUM_HI) begin
            byte_pos = POS_HUNT;
            if ({b, low_hold} != frame_sum) begin
                r = '{STATUS_CSUM_ERR, '0, '0, 1'b1};
                results_due.push_back(r);
            end else begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r = '{STATUS_OK, IDX_W'(i), chan_words[i], i == CHANNELS - 1};
                    results_due.push_back(r);
                end
            end
        end else begin
            byte_pos = POS_HUNT;
        end
    endfunction

    always @(posedge aclk) begin
        chan_result_t due;
        if (!aresetn) begin
            byte_pos  = POS_HUNT;
            frame_sum = SUM_INIT;
            low_hold  = '0;
            n_fail    = 0;
            results_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $error("result transaction with none expected: tdata %h", m_tdata);
                    n_fail++;
                end else begin
                    due = results_due.pop_front();
                    if (m_tuser !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, m_tuser);
                        n_fail++;
                    end
                    if (m_tdata[IDX_W-1:0] !== due.chan_idx) begin
                        $error("channel_index: expected %0d, got %0d",
                               due.chan_idx, m_tdata[IDX_W-1:0]);
                        n_fail++;
                    end
                    if (m_tdata[IDX_W+VAL_W-1:IDX_W] !== due.chan_val) begin
                        $error("channel_value: expected %h, got %h",
                               due.chan_val, m_tdata[IDX_W+VAL_W-1:IDX_W]);
                        n_fail++;
                    end
                    if (m_tlast !== due.is_last) begin
                        $error("last: expected %0d, got %0d", due.is_last, m_tlast);
                        n_fail++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata[BYTE_W-1:0]);
        end
        fail_count <= n_fail;
        pending    <= results_due.size();
    end

endmodule

[bench/testbench.sv]
// ============================================================================
// testbench: stream-level test of the serial frame receiver
// Feeds byte noise, broken headers, good frames and frames with a bad
// checksum, with random gaps and output stalls; the checker predicts and
// compares every result and reports failures for the verdict.
// ============================================================================
module testbench import ibfr_pkg::*;;

    localparam int ITEM_GOAL      = 330;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 60;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int                   fail_count;
    int                   pending;
    int                   bytes_sent = 0;
    int                   idle_cycles = 0;
    int                   stall_left = 0;
    bit                   send_gaps = 1'b0;
    logic                 ready_stalls = 1'b0;
    logic [VAL_W-1:0]     frame_words [CHANNELS];

    ibus_frame_receiver u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ibfr_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // output backpressure in bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (ready_stalls && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 14);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (send_gaps && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit bad_sum);
        logic [VAL_W-1:0] sum;
        sum = SUM_INIT - VAL_W'(HDR0) - VAL_W'(HDR1);
        send_byte(HDR0);
        send_byte(HDR1);
        for (int i = 0; i < CHANNELS; i++) begin
            send_byte(frame_words[i][7:0]);
            send_byte(frame_words[i][15:8]);
            sum = sum - VAL_W'(frame_words[i][7:0]) - VAL_W'(frame_words[i][15:8]);
        end
        if (bad_sum)
            sum = sum ^ VAL_W'($urandom_range(1, 16'hFFFF));
        send_byte(sum[7:0]);
        send_byte(sum[15:8]);
    endtask

    // stray bytes and broken headers; leaves the receiver hunting
    task automatic send_noise();
        logic [BYTE_W-1:0] b;
        repeat ($urandom_range(1, 6)) begin
            b = BYTE_W'($urandom);
            if ($urandom_range(0, 2) == 0) begin
                if (b == HDR1)
                    b = ~b;
                send_byte(HDR0);
                send_byte(b);
            end else begin
                if (b == HDR0)
                    b = ~b;
                send_byte(b);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {HDR1, HDR0};
            default: return VAL_W'($urandom);
        endcase
    endfunction

    initial begin
        int  kind;
        logic stalls;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hunting noise, second header byte wrong (also a repeated 0x20)
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR1);
        send_byte(HDR0);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR0);
        send_byte(~HDR1);

        for (int i = 0; i < CHANNELS; i++)
            frame_words[i] = pick_word();
        frame_words[0] = 16'h0000;
        frame_words[1] = 16'hFFFF;
        frame_words[2] = 16'h00FF;
        frame_words[3] = 16'hFF00;
        frame_words[4] = {HDR1, HDR0};
        frame_words[5] = {HDR0, HDR1};
        frame_words[6] = 16'h0001;
        frame_words[7] = 16'h8000;
        send_frame(1'b0);
        for (int i = 0; i < CHANNELS; i++)
            frame_words[i] = 16'hFFFF;
        send_frame(1'b1);
        wait_drained();

        while (bytes_sent < ITEM_GOAL) begin
            if (bytes_sent > ITEM_GOAL * 4 / 5) begin
                send_gaps = 1'b0;
                stalls    = 1'b0;
            end else begin
                send_gaps = $urandom_range(0, 2) != 0;
                stalls    = $urandom_range(0, 2) != 0;
            end
            ready_stalls <= stalls;
            kind = $urandom_range(0, 19);
            if (kind < 17) begin
                for (int i = 0; i < CHANNELS; i++)
                    frame_words[i] = pick_word();
                send_frame(kind >= 14);
            end else begin
                send_noise();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
